### rtl/ptea_pkg.sv
// ============================================================================
// ptea_pkg: shared types and constants for the table entry allocator
// Table geometry, command and result codes, channel payloads and the
// control bundle between the sequencer and the entry table.
// ============================================================================
package ptea_pkg;

    // Table geometry
    localparam int NUM_INTERFACES        = 4;
    localparam int ENTRIES_PER_INTERFACE = 64;
    localparam int TABLE_SIZE            = NUM_INTERFACES * ENTRIES_PER_INTERFACE;
    localparam int TAB_AW                = $clog2(TABLE_SIZE);

    // Free-map scan: one chunk of entries per cycle through the priority unit
    localparam int SCAN_W     = (ENTRIES_PER_INTERFACE < 16) ? ENTRIES_PER_INTERFACE : 16;
    localparam int NUM_CHUNKS = (ENTRIES_PER_INTERFACE + SCAN_W - 1) / SCAN_W;
    localparam int CHUNK_AW   = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int SEL_W      = $clog2(SCAN_W);

    // Entry position within one interface, wide enough for any scan position
    localparam int J_W = 9;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int NI_W     = 3;
    localparam int CODE_W   = 3;
    localparam int IDX_W    = 8;
    localparam int WORD_W   = 32;
    localparam int RC_W     = 3;
    localparam int ST_W     = 2;
    localparam int MASK_W   = 4;
    localparam int MASK_AW  = 2;
    localparam int MAXI_W   = 6;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [RC_W-1:0] {
        RC_OK        = 3'd0,
        RC_NO_INIT   = 3'd1,
        RC_ARG       = 3'd2,
        RC_EQ_NEEDED = 3'd3,
        RC_IN_USE    = 3'd4,
        RC_FULL      = 3'd5
    } rc_t;

    typedef enum logic [ST_W-1:0] {
        ST_FREE    = 2'd0,
        ST_ENABLED = 2'd1
    } status_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_INITIALIZED = 2'd0,
        REG_NI_ACTIVE   = 2'd1,
        REG_MAX_INDEX   = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_READ,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [NI_W-1:0]   ni_index;
        logic [CODE_W-1:0] handle_code;
        logic              any_index;
        logic [IDX_W-1:0]  entry_index;
        logic [WORD_W-1:0] options;
        logic              flow_control;
        logic [WORD_W-1:0] evq_handle;
        logic              eq_is_none;
        logic              eq_valid;
        logic              lists_busy;
    } req_t;

    typedef struct packed {
        logic [RC_W-1:0]   result_code;
        logic [IDX_W-1:0]  index_out;
        logic [ST_W-1:0]   status_out;
        logic [WORD_W-1:0] eq_out;
        logic [WORD_W-1:0] options_out;
    } rsp_t;

    typedef struct packed {
        logic [CFG_AW-1:0] index;
        logic [CFG_DW-1:0] value;
    } cfg_t;

    typedef struct packed {
        logic              initialized;
        logic [MASK_W-1:0] ni_active_mask;
        logic [MAXI_W-1:0] max_index;
    } cfg_regs_t;

    // Sequencer to table control bundle
    typedef struct packed {
        logic              set_used;
        logic              clr_used;
        logic              wr_en;
        logic              rd_en;
        logic [TAB_AW-1:0] addr;
        logic [WORD_W-1:0] eq;
        logic [WORD_W-1:0] opts;
    } tbl_op_t;

    // Flat table address of entry j of interface ni
    function automatic logic [TAB_AW-1:0] entry_addr(input logic [NI_W-1:0] ni,
                                                     input logic [J_W-1:0]  j);
        logic [TAB_AW+J_W-1:0] full;
        full = (TAB_AW+J_W)'(ni) * (TAB_AW+J_W)'(ENTRIES_PER_INTERFACE)
             + (TAB_AW+J_W)'(j);
        return full[TAB_AW-1:0];
    endfunction

    // Entry position usable under the current highest index
    function automatic logic index_ok(input logic [J_W-1:0]    j,
                                      input logic [MAXI_W-1:0] max_idx);
        return (j <= J_W'(max_idx)) && (j < J_W'(ENTRIES_PER_INTERFACE));
    endfunction

endpackage

### rtl/ptea_if.sv
// ============================================================================
// ptea_if: valid/ready channels of the table entry allocator
// Request, response and configuration-write channels.
// ============================================================================
interface ptea_req_if;
    logic          valid;
    logic          ready;
    ptea_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ptea_rsp_if;
    logic          valid;
    logic          ready;
    ptea_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ptea_cfg_if;
    logic          valid;
    logic          ready;
    ptea_pkg::cfg_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/ptea_table.sv
// ============================================================================
// ptea_table: entry table storage
// In-use flags per entry (cleared at reset), event-queue handle and options
// memories with registered read, and a chunk view of the in-use flags.
// ============================================================================
module ptea_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ptea_pkg::tbl_op_t                 op,
    input  logic [ptea_pkg::TAB_AW-1:0]       chunk_addr,
    output logic                              used_bit,
    output logic [ptea_pkg::SCAN_W-1:0]       chunk_used,
    output logic [ptea_pkg::WORD_W-1:0]       rd_eq,
    output logic [ptea_pkg::WORD_W-1:0]       rd_opts
);

    logic [ptea_pkg::TABLE_SIZE-1:0] used_reg;
    logic [ptea_pkg::TABLE_SIZE-1:0] used_next;

    logic [ptea_pkg::WORD_W-1:0] queue_mem [ptea_pkg::TABLE_SIZE];
    logic [ptea_pkg::WORD_W-1:0] opts_mem  [ptea_pkg::TABLE_SIZE];
    logic [ptea_pkg::WORD_W-1:0] rd_eq_reg;
    logic [ptea_pkg::WORD_W-1:0] rd_opts_reg;

    // Set or clear one in-use flag
    always_comb
    begin
        used_next = used_reg;
        if (op.set_used)
        begin
            used_next[op.addr] = 1'b1;
        end
        else if (op.clr_used)
        begin
            used_next[op.addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    // Flag of the addressed entry and of the chunk under scan
    always_comb
    begin
        logic [ptea_pkg::TAB_AW-1:0] pos;
        pos      = '0;
        used_bit = used_reg[op.addr];
        for (int b = 0; b < ptea_pkg::SCAN_W; b++)
        begin
            pos           = chunk_addr + ptea_pkg::TAB_AW'(b);
            chunk_used[b] = used_reg[pos];
        end
    end

    // Handle and options memories
    always_ff @(posedge clk)
    begin
        if (op.wr_en)
        begin
            queue_mem[op.addr] <= op.eq;
            opts_mem[op.addr]  <= op.opts;
        end
        if (op.rd_en)
        begin
            rd_eq_reg   <= queue_mem[op.addr];
            rd_opts_reg <= opts_mem[op.addr];
        end
    end

    assign rd_eq   = rd_eq_reg;
    assign rd_opts = rd_opts_reg;

endmodule

### rtl/ptea_seq.sv
// ============================================================================
// ptea_seq: command sequencer
// Checks a request, drives the table, scans the free map one chunk a cycle
// through a shared priority unit and holds the response in an output register.
// ============================================================================
module ptea_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ptea_pkg::cfg_regs_t            regs,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  ptea_pkg::req_t                 req_data,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output ptea_pkg::rsp_t                 rsp_data,
    output ptea_pkg::tbl_op_t              op,
    output logic [ptea_pkg::TAB_AW-1:0]    chunk_addr,
    input  logic                           used_bit,
    input  logic [ptea_pkg::SCAN_W-1:0]    chunk_used,
    input  logic [ptea_pkg::WORD_W-1:0]    rd_eq,
    input  logic [ptea_pkg::WORD_W-1:0]    rd_opts
);

    ptea_pkg::seq_state_t              state_reg, state_next;
    ptea_pkg::req_t                    req_reg;
    logic [ptea_pkg::CHUNK_AW-1:0]     chunk_reg, chunk_next;
    ptea_pkg::rsp_t                    res_reg, res_next;
    logic                              rsp_valid_reg, rsp_valid_next;
    ptea_pkg::rsp_t                    rsp_data_reg, rsp_data_next;

    // Check results
    ptea_pkg::rc_t                     chk_rc;
    logic                              chk_write;
    logic                              chk_clear;
    logic                              chk_scan;
    logic                              chk_read;
    logic [ptea_pkg::J_W-1:0]          j_req;

    // Scan unit
    logic [ptea_pkg::J_W-1:0]          scan_base_j;
    logic [ptea_pkg::J_W-1:0]          next_start;
    logic [ptea_pkg::J_W-1:0]          hit_j;
    logic [ptea_pkg::SCAN_W-1:0]       cand;
    logic [ptea_pkg::SEL_W-1:0]        first;
    logic                              hit;
    logic                              scan_last;

    logic                              req_fire;

    assign req_ready = (state_reg == ptea_pkg::S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign j_req     = ptea_pkg::J_W'(req_reg.entry_index);

    // Argument checks and command decode
    always_comb
    begin
        logic ni_ok;
        logic active;
        logic idx_ok;
        ni_ok     = {1'b0, req_reg.ni_index} < 4'(ptea_pkg::NUM_INTERFACES);
        active    = ({1'b0, req_reg.ni_index} < 4'(ptea_pkg::MASK_W)) &&
                    regs.ni_active_mask[req_reg.ni_index[ptea_pkg::MASK_AW-1:0]];
        idx_ok    = ptea_pkg::index_ok(j_req, regs.max_index);
        chk_rc    = ptea_pkg::RC_OK;
        chk_write = 1'b0;
        chk_clear = 1'b0;
        chk_scan  = 1'b0;
        chk_read  = 1'b0;
        if (!regs.initialized)
        begin
            chk_rc = ptea_pkg::RC_NO_INIT;
        end
        else if (!ni_ok || req_reg.handle_code != '0 || !active)
        begin
            chk_rc = ptea_pkg::RC_ARG;
        end
        else
        begin
            case (req_reg.command)
                ptea_pkg::CMD_ALLOC:
                begin
                    if (req_reg.eq_is_none && req_reg.flow_control)
                    begin
                        chk_rc = ptea_pkg::RC_EQ_NEEDED;
                    end
                    else if (!req_reg.eq_valid)
                    begin
                        chk_rc = ptea_pkg::RC_ARG;
                    end
                    else if (req_reg.any_index)
                    begin
                        chk_scan = 1'b1;
                    end
                    else if (!idx_ok)
                    begin
                        chk_rc = ptea_pkg::RC_ARG;
                    end
                    else if (used_bit)
                    begin
                        chk_rc = ptea_pkg::RC_IN_USE;
                    end
                    else
                    begin
                        chk_write = 1'b1;
                    end
                end
                ptea_pkg::CMD_FREE:
                begin
                    if (req_reg.any_index || !idx_ok)
                    begin
                        chk_rc = ptea_pkg::RC_ARG;
                    end
                    else if (req_reg.lists_busy)
                    begin
                        chk_rc = ptea_pkg::RC_IN_USE;
                    end
                    else if (!used_bit)
                    begin
                        chk_rc = ptea_pkg::RC_ARG;
                    end
                    else
                    begin
                        chk_clear = 1'b1;
                    end
                end
                ptea_pkg::CMD_QUERY:
                begin
                    if (req_reg.any_index || !idx_ok)
                    begin
                        chk_rc = ptea_pkg::RC_ARG;
                    end
                    else
                    begin
                        chk_read = 1'b1;
                    end
                end
                default:
                begin
                    chk_rc = ptea_pkg::RC_ARG;
                end
            endcase
        end
    end

    // Lowest free entry in the current chunk
    always_comb
    begin
        logic [ptea_pkg::J_W-1:0] j;
        j           = '0;
        scan_base_j = ptea_pkg::J_W'(chunk_reg) * ptea_pkg::J_W'(ptea_pkg::SCAN_W);
        next_start  = scan_base_j + ptea_pkg::J_W'(ptea_pkg::SCAN_W);
        chunk_addr  = ptea_pkg::entry_addr(req_reg.ni_index, scan_base_j);
        for (int b = 0; b < ptea_pkg::SCAN_W; b++)
        begin
            j       = scan_base_j + ptea_pkg::J_W'(b);
            cand[b] = !chunk_used[b] && ptea_pkg::index_ok(j, regs.max_index);
        end
        first = '0;
        for (int b = ptea_pkg::SCAN_W - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                first = ptea_pkg::SEL_W'(b);
            end
        end
        hit       = |cand;
        hit_j     = scan_base_j + ptea_pkg::J_W'(first);
        scan_last = (chunk_reg == ptea_pkg::CHUNK_AW'(ptea_pkg::NUM_CHUNKS - 1)) ||
                    !ptea_pkg::index_ok(next_start, regs.max_index);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptea_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ptea_pkg::S_CHECK;
                end
            end
            ptea_pkg::S_CHECK:
            begin
                if (chk_scan)
                begin
                    state_next = ptea_pkg::S_SCAN;
                end
                else if (chk_read)
                begin
                    state_next = ptea_pkg::S_READ;
                end
                else
                begin
                    state_next = ptea_pkg::S_DONE;
                end
            end
            ptea_pkg::S_SCAN:
            begin
                if (hit || scan_last)
                begin
                    state_next = ptea_pkg::S_DONE;
                end
            end
            ptea_pkg::S_READ:
            begin
                state_next = ptea_pkg::S_DONE;
            end
            ptea_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ptea_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ptea_pkg::S_IDLE;
            end
        endcase
    end

    // Table control, result and response register
    always_comb
    begin
        op             = '0;
        op.addr        = ptea_pkg::entry_addr(req_reg.ni_index, j_req);
        op.eq          = req_reg.evq_handle;
        op.opts        = req_reg.options;
        res_next       = res_reg;
        chunk_next     = chunk_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_data_next  = rsp_data_reg;
        case (state_reg)
            ptea_pkg::S_CHECK:
            begin
                op.set_used          = chk_write;
                op.wr_en             = chk_write;
                op.clr_used          = chk_clear;
                op.rd_en             = chk_read;
                chunk_next           = '0;
                res_next             = '0;
                res_next.result_code = chk_rc;
                if (chk_write || chk_clear)
                begin
                    res_next.index_out = req_reg.entry_index;
                end
                if (chk_write)
                begin
                    res_next.status_out = ptea_pkg::ST_ENABLED;
                end
            end
            ptea_pkg::S_SCAN:
            begin
                chunk_next = chunk_reg + 1'b1;
                if (hit)
                begin
                    op.addr             = ptea_pkg::entry_addr(req_reg.ni_index, hit_j);
                    op.set_used         = 1'b1;
                    op.wr_en            = 1'b1;
                    res_next            = '0;
                    res_next.index_out  = hit_j[ptea_pkg::IDX_W-1:0];
                    res_next.status_out = ptea_pkg::ST_ENABLED;
                end
                else if (scan_last)
                begin
                    res_next             = '0;
                    res_next.result_code = ptea_pkg::RC_FULL;
                end
            end
            ptea_pkg::S_READ:
            begin
                res_next           = '0;
                res_next.index_out = req_reg.entry_index;
                if (used_bit)
                begin
                    res_next.status_out  = ptea_pkg::ST_ENABLED;
                    res_next.eq_out      = rd_eq;
                    res_next.options_out = rd_opts;
                end
            end
            ptea_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ptea_pkg::S_IDLE;
            chunk_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chunk_reg     <= chunk_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req_data;
        end
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // An accepted request always enters the check step
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg == ptea_pkg::S_CHECK)
        else $error("accepted request did not enter check");

    // The scan never runs beyond the last chunk
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ptea_pkg::S_SCAN |->
            chunk_reg <= ptea_pkg::CHUNK_AW'(ptea_pkg::NUM_CHUNKS - 1))
        else $error("scan past last chunk");

    // A flag is never set and cleared together, and writes go with a set
    a_table_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(op.set_used && op.clr_used) && (op.wr_en == op.set_used))
        else $error("inconsistent table operation");

    // A response appears only out of the done step
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ptea_pkg::S_DONE))
        else $error("response raised outside done step");

endmodule

### rtl/portal_table_entry_allocator.sv
// ============================================================================
// portal_table_entry_allocator: per-interface table entry allocator
// Top level: configuration registers, sequencer and entry table.
// ============================================================================
// One request is handled at a time and the request channel is not ready until
// its response has been handed to the output register. Free, query of a bad
// argument, allocate at a given index and every failing check go from the
// check step straight to the done step; a successful query passes through a
// read step as well, since the handle and options memories have a registered
// read. Allocate of any free entry scans the interface's free map SCAN_W (16)
// entries per cycle through one priority encoder. In-use flags are cleared
// by reset directly, so no clearing pass runs after reset. A pending response
// waits in the output register while the next request is taken.
module portal_table_entry_allocator (
    input  logic       clk,
    input  logic       rst_n,
    ptea_req_if.sink   req,
    ptea_rsp_if.source rsp,
    ptea_cfg_if.sink   cfg
);

    ptea_pkg::cfg_regs_t                 regs_reg, regs_next;
    ptea_pkg::tbl_op_t                   op;
    logic [ptea_pkg::TAB_AW-1:0]         chunk_addr;
    logic                                used_bit;
    logic [ptea_pkg::SCAN_W-1:0]         chunk_used;
    logic [ptea_pkg::WORD_W-1:0]         rd_eq;
    logic [ptea_pkg::WORD_W-1:0]         rd_opts;

    assign cfg.ready = 1'b1;

    // Decode configuration writes
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.data.index)
                ptea_pkg::REG_INITIALIZED:
                begin
                    regs_next.initialized = cfg.data.value[0];
                end
                ptea_pkg::REG_NI_ACTIVE:
                begin
                    regs_next.ni_active_mask = cfg.data.value[ptea_pkg::MASK_W-1:0];
                end
                ptea_pkg::REG_MAX_INDEX:
                begin
                    regs_next.max_index = cfg.data.value[ptea_pkg::MAXI_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.initialized    <= 1'b0;
            regs_reg.ni_active_mask <= '0;
            regs_reg.max_index      <= '1;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    ptea_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .regs       (regs_reg),
        .req_valid  (req.valid),
        .req_ready  (req.ready),
        .req_data   (req.data),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .rsp_data   (rsp.data),
        .op         (op),
        .chunk_addr (chunk_addr),
        .used_bit   (used_bit),
        .chunk_used (chunk_used),
        .rd_eq      (rd_eq),
        .rd_opts    (rd_opts)
    );

    ptea_table u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .chunk_addr (chunk_addr),
        .used_bit   (used_bit),
        .chunk_used (chunk_used),
        .rd_eq      (rd_eq),
        .rd_opts    (rd_opts)
    );

endmodule
